// File: hdl/sida_pkg.sv
// Package for the signed integer to decimal ASCII unit.
// Holds widths, character codes and the controller state type.
// No dependencies.
package sida_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned CharWidth   = 8;
  localparam int unsigned NumDigits   = 10;
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned BcdWidth    = NumDigits * DigitWidth;
  localparam int unsigned BitCntWidth = $clog2(ValueWidth);
  localparam int unsigned DigCntWidth = $clog2(NumDigits + 1);

  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharMinus = 8'h2D;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSign,
    StDigits
  } state_e;

endpackage

// File: hdl/sida_stream_if.sv
// Valid/ready channel interfaces of the signed integer to decimal ASCII unit.
// Depends on sida_pkg for the payload widths.
interface sida_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sida_pkg::ValueWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sida_out_if;
  logic                             valid;
  logic                             ready;
  logic [sida_pkg::CharWidth-1:0]   char_code;
  logic                             is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// File: hdl/signed_int_to_decimal_ascii_unit.sv
// Signed 32-bit integer to decimal ASCII text, one character per output item.
// Bit-serial binary to BCD conversion comes first, then the sign of a negative value,
// then each digit position in turn (leading zero skipped or character sent). Output
// stalls can hold the sign and the digits. A new value is accepted only in idle,
// once the last character of the previous value has been loaded.
// Reset (asynchronous, active low) returns the controller to idle with no output.
module signed_int_to_decimal_ascii_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  sida_in_if.sink      in_i,
  sida_out_if.source   out_o
);

  localparam int unsigned VW = sida_pkg::ValueWidth;
  localparam int unsigned BW = sida_pkg::BcdWidth;
  localparam int unsigned DW = sida_pkg::DigitWidth;

  sida_pkg::state_e state_q, state_d;

  logic [VW-1:0]                        mag_q, mag_d;
  logic [BW-1:0]                        bcd_q, bcd_d;
  logic [BW-1:0]                        bcd_adj;
  logic                                 neg_q, neg_d;
  logic [sida_pkg::BitCntWidth-1:0]     bit_cnt_q, bit_cnt_d;
  logic [sida_pkg::DigCntWidth-1:0]     dig_cnt_q, dig_cnt_d;
  logic                                 started_q, started_d;
  logic                                 ovalid_q, ovalid_d;
  logic [sida_pkg::CharWidth-1:0]       ochar_q, ochar_d;
  logic                                 olast_q, olast_d;

  logic          out_free;
  logic [DW-1:0] top_digit;
  logic          last_digit;
  logic          skip_zero;
  logic          in_accept;
  logic          conv_done;

  assign out_free   = !ovalid_q || out_o.ready;
  assign top_digit  = bcd_q[BW-1 -: DW];
  assign last_digit = (dig_cnt_q == sida_pkg::DigCntWidth'(1));
  assign skip_zero  = !started_q && (top_digit == '0) && !last_digit;
  assign in_accept  = in_i.valid && in_i.ready;
  assign conv_done  = (bit_cnt_q == sida_pkg::BitCntWidth'(VW - 1));

  assign in_i.ready      = (state_q == sida_pkg::StIdle);
  assign out_o.valid     = ovalid_q;
  assign out_o.char_code = ochar_q;
  assign out_o.is_last   = olast_q;

  // Add-3 correction on every BCD digit that is 5 or more, ahead of the shift.
  always_comb begin
    for (int d = 0; d < int'(sida_pkg::NumDigits); d++) begin
      if (bcd_q[d*DW +: DW] >= DW'(5)) begin
        bcd_adj[d*DW +: DW] = bcd_q[d*DW +: DW] + DW'(3);
      end else begin
        bcd_adj[d*DW +: DW] = bcd_q[d*DW +: DW];
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sida_pkg::StIdle: begin
        if (in_i.valid) state_d = sida_pkg::StConv;
      end
      sida_pkg::StConv: begin
        if (conv_done) state_d = neg_q ? sida_pkg::StSign : sida_pkg::StDigits;
      end
      sida_pkg::StSign: begin
        if (out_free) state_d = sida_pkg::StDigits;
      end
      sida_pkg::StDigits: begin
        if (!skip_zero && out_free && last_digit) state_d = sida_pkg::StIdle;
      end
      default: state_d = sida_pkg::StIdle;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    mag_d     = mag_q;
    bcd_d     = bcd_q;
    neg_d     = neg_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    started_d = started_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    ochar_d   = ochar_q;
    olast_d   = olast_q;
    unique case (state_q)
      sida_pkg::StIdle: begin
        if (in_i.valid) begin
          neg_d     = in_i.value[VW-1];
          mag_d     = in_i.value[VW-1] ? (VW'(0) - VW'(in_i.value)) : VW'(in_i.value);
          bcd_d     = '0;
          bit_cnt_d = '0;
        end
      end
      sida_pkg::StConv: begin
        bcd_d     = {bcd_adj[BW-2:0], mag_q[VW-1]};
        mag_d     = {mag_q[VW-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + sida_pkg::BitCntWidth'(1);
        dig_cnt_d = sida_pkg::DigCntWidth'(sida_pkg::NumDigits);
        started_d = 1'b0;
      end
      sida_pkg::StSign: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ochar_d  = sida_pkg::CharMinus;
          olast_d  = 1'b0;
        end
      end
      sida_pkg::StDigits: begin
        if (skip_zero) begin
          bcd_d     = {bcd_q[BW-DW-1:0], {DW{1'b0}}};
          dig_cnt_d = dig_cnt_q - sida_pkg::DigCntWidth'(1);
        end else if (out_free) begin
          ovalid_d  = 1'b1;
          ochar_d   = sida_pkg::CharZero + {{(sida_pkg::CharWidth-DW){1'b0}}, top_digit};
          olast_d   = last_digit;
          bcd_d     = {bcd_q[BW-DW-1:0], {DW{1'b0}}};
          dig_cnt_d = dig_cnt_q - sida_pkg::DigCntWidth'(1);
          started_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sida_pkg::StIdle;
      ovalid_q  <= 1'b0;
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
      started_q <= 1'b0;
      neg_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      ovalid_q  <= ovalid_d;
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
      started_q <= started_d;
      neg_q     <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    bcd_q   <= bcd_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  // An accepted item always starts a conversion.
  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == sida_pkg::StConv))
    else $error("accepted item did not start conversion");

  // A minus sign is never the final character.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && (ochar_q == sida_pkg::CharMinus)) |-> !olast_q)
    else $error("minus sign flagged as last character");

  // The sign state is entered only for negative values.
  a_sign_only_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sida_pkg::StSign) |-> neg_q)
    else $error("sign state entered for a non-negative value");

  // The digit phase always has at least one digit left to send.
  a_digits_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sida_pkg::StDigits) |-> (dig_cnt_q != '0))
    else $error("digit phase with no digits left");

  // Returning to idle happens only right after the last character is loaded.
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == sida_pkg::StDigits) && (state_d == sida_pkg::StIdle)) |=> (ovalid_q && olast_q))
    else $error("returned to idle without loading the last character");

endmodule
